[src/crt_timing_controller_top_assert.svh]
// Assertion macros shared by the checker of the CRT timing controller.
// Depends on nothing; included by the checker file.
`ifndef CRT_TIMING_CONTROLLER_TOP_ASSERT_SVH
`define CRT_TIMING_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CRTC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("CRT timing controller same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define CRTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("CRT timing controller next-cycle check failed");

`endif

[src/crtc_pkg.sv]
// Package for the CRT timing controller: transfer types, mode codes,
// register indexes and the per-register default, mask and access tables.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package crtc_pkg;

   localparam int REG_COUNT = 18;
   localparam int REG_IDX_W = 5;

   localparam logic [2:0] MODE_TICK     = 3'd0;
   localparam logic [2:0] MODE_WR_INDEX = 3'd1;
   localparam logic [2:0] MODE_RD_INDEX = 3'd2;
   localparam logic [2:0] MODE_WR_DATA  = 3'd3;
   localparam logic [2:0] MODE_RD_DATA  = 3'd4;

   localparam logic [REG_IDX_W-1:0] REG_H_TOTAL   = 5'd0;
   localparam logic [REG_IDX_W-1:0] REG_H_SYNC    = 5'd2;
   localparam logic [REG_IDX_W-1:0] REG_SYNC_W    = 5'd3;
   localparam logic [REG_IDX_W-1:0] REG_V_TOTAL   = 5'd4;
   localparam logic [REG_IDX_W-1:0] REG_V_ADJUST  = 5'd5;
   localparam logic [REG_IDX_W-1:0] REG_V_SYNC    = 5'd7;
   localparam logic [REG_IDX_W-1:0] REG_MAX_LINE  = 5'd9;

   localparam logic [7:0] REG_DEFAULTS [REG_COUNT] = '{
      8'h3f, 8'h28, 8'h2e, 8'h0e, 8'h26, 8'h00, 8'h19, 8'h1e, 8'h00,
      8'h07, 8'h00, 8'h00, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   localparam logic [7:0] REG_MASKS [REG_COUNT] = '{
      8'hff, 8'hff, 8'hff, 8'h0f, 8'h7f, 8'h1f, 8'h7f, 8'h7f, 8'h03,
      8'h1f, 8'h7f, 8'h1f, 8'h3f, 8'hff, 8'h3f, 8'hff, 8'h3f, 8'hff
   };

   // Registers 0 to 15 accept writes; 14 to 17 may be read back.
   localparam logic [REG_COUNT-1:0] REG_WR_PERMIT = 18'b00_1111_1111_1111_1111;
   localparam logic [REG_COUNT-1:0] REG_RD_PERMIT = 18'b11_1100_0000_0000_0000;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] bus_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       hsync_level;
      logic       vsync_level;
      logic       hsync_changed;
      logic       vsync_changed;
   } rsp_type;

endpackage

`default_nettype wire

[src/crt_timing_controller_top.sv]
// CRT timing controller: register file, character, scanline and row counters,
// horizontal and vertical sync generation, all in one registered pass.
// Depends on crtc_pkg.
//
// Usage:
// Each transfer on the req_ channel is either one character-clock tick or
// one bus access (index write, index read, data write, data read). Every
// accepted transfer yields exactly one transfer on the rsp_ channel carrying
// the returned byte and the sync levels with their change flags.
// The result is registered and is valid on the cycle after acceptance.
// Throughput is one item per cycle while the receiver does not stall; the next
// item is taken while the previous result is being offered, since the output
// register frees itself in the same cycle that its result is taken.
// When the receiver stalls, the result holds in the output register and
// req_stall is raised, so no further item is accepted until it moves.
// A synchronous reset restores the register defaults, clears the counters,
// the selected index and both sync levels, and empties the output register.
// req_stall is high during reset.
`timescale 1ns / 1ps
`default_nettype none

module crt_timing_controller_top (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_stall,
   input  wire crtc_pkg::req_type req_data,
   output      logic            rsp_valid,
   input  wire logic            rsp_stall,
   output      crtc_pkg::rsp_type rsp_data
);

   logic [7:0] regs_ff [crtc_pkg::REG_COUNT];
   logic [7:0] sel_ff, sel_in;
   logic [7:0] char_ff, char_in;
   logic [7:0] row_ff, row_in;
   logic [7:0] line_ff, line_in;
   logic [3:0] hwidth_ff, hwidth_in;
   logic [3:0] vwidth_ff, vwidth_in;
   logic       hsync_ff, hsync_in;
   logic       vsync_ff, vsync_in;
   logic       rsp_valid_ff, rsp_valid_in;
   crtc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic       accept;
   logic       wr_en;
   logic [7:0] wr_data;
   logic [crtc_pkg::REG_IDX_W-1:0] idx;
   logic       idx_ok;
   logic [7:0] h_total, v_total, sl_total;
   logic [3:0] h_width, v_width, w_next;
   logic       next_line, next_row;
   logic [7:0] read_val;

   assign req_stall = reset | (rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign idx_ok = (sel_ff < 8'(crtc_pkg::REG_COUNT));
   assign idx    = sel_ff[crtc_pkg::REG_IDX_W-1:0];

   always_comb begin
      sel_in    = sel_ff;
      char_in   = char_ff;
      row_in    = row_ff;
      line_in   = line_ff;
      hwidth_in = hwidth_ff;
      vwidth_in = vwidth_ff;
      hsync_in  = hsync_ff;
      vsync_in  = vsync_ff;
      wr_en     = 1'b0;
      wr_data   = req_data.bus_byte;
      next_line = 1'b0;
      next_row  = 1'b0;
      w_next    = 4'd0;
      read_val  = idx_ok ? (regs_ff[idx] & crtc_pkg::REG_MASKS[idx]) : 8'd0;

      h_total = regs_ff[crtc_pkg::REG_H_TOTAL] + 8'd1;
      v_total = regs_ff[crtc_pkg::REG_V_TOTAL] + 8'd1;
      h_width = regs_ff[crtc_pkg::REG_SYNC_W][3:0];
      v_width = regs_ff[crtc_pkg::REG_SYNC_W][7:4];
      sl_total = regs_ff[crtc_pkg::REG_MAX_LINE] + 8'd1;
      if (({1'b0, row_ff} + 9'd1) == {1'b0, v_total}) begin
         sl_total = sl_total + regs_ff[crtc_pkg::REG_V_ADJUST];
      end

      rsp_data_in.read_byte     = 8'd0;
      rsp_data_in.hsync_changed = 1'b0;
      rsp_data_in.vsync_changed = 1'b0;

      case (req_data.mode)
         crtc_pkg::MODE_TICK: begin
            char_in = char_ff + 8'd1;
            if (char_in == h_total) begin
               char_in   = 8'd0;
               next_line = 1'b1;
            end
            if (hsync_ff) begin
               w_next    = hwidth_ff + 4'd1;
               hwidth_in = w_next;
               if (w_next == h_width) begin
                  hwidth_in = 4'd0;
                  hsync_in  = 1'b0;
               end
            end else if (char_in == regs_ff[crtc_pkg::REG_H_SYNC]) begin
               hwidth_in = 4'd0;
               hsync_in  = 1'b1;
            end
            if (next_line) begin
               line_in = line_ff + 8'd1;
               if (line_in == sl_total) begin
                  line_in  = 8'd0;
                  next_row = 1'b1;
               end
               if (vsync_ff) begin
                  vwidth_in = vwidth_ff + 4'd1;
                  if (vwidth_in == v_width) begin
                     vwidth_in = 4'd0;
                     vsync_in  = 1'b0;
                  end
               end else if (row_ff == regs_ff[crtc_pkg::REG_V_SYNC]) begin
                  vwidth_in = 4'd0;
                  vsync_in  = 1'b1;
               end
            end
            if (next_row) begin
               row_in = row_ff + 8'd1;
               if (row_in == v_total) begin
                  row_in = 8'd0;
               end
            end
            rsp_data_in.hsync_changed = hsync_in ^ hsync_ff;
            rsp_data_in.vsync_changed = vsync_in ^ vsync_ff;
         end
         crtc_pkg::MODE_WR_INDEX: begin
            sel_in                = req_data.bus_byte;
            rsp_data_in.read_byte = req_data.bus_byte;
         end
         crtc_pkg::MODE_RD_INDEX: begin
            rsp_data_in.read_byte = req_data.bus_byte;
         end
         crtc_pkg::MODE_WR_DATA: begin
            rsp_data_in.read_byte = req_data.bus_byte;
            if (idx_ok && crtc_pkg::REG_WR_PERMIT[idx]) begin
               wr_en                 = 1'b1;
               wr_data               = req_data.bus_byte & crtc_pkg::REG_MASKS[idx];
               rsp_data_in.read_byte = wr_data;
            end
         end
         crtc_pkg::MODE_RD_DATA: begin
            rsp_data_in.read_byte = req_data.bus_byte;
            if (idx_ok && crtc_pkg::REG_RD_PERMIT[idx]) begin
               rsp_data_in.read_byte = read_val;
            end
         end
         default: begin
            rsp_data_in.read_byte = 8'd0;
         end
      endcase

      rsp_data_in.hsync_level = hsync_in;
      rsp_data_in.vsync_level = vsync_in;
      rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < crtc_pkg::REG_COUNT; i++) begin
            regs_ff[i] <= crtc_pkg::REG_DEFAULTS[i];
         end
         sel_ff       <= 8'd0;
         char_ff      <= 8'd0;
         row_ff       <= 8'd0;
         line_ff      <= 8'd0;
         hwidth_ff    <= 4'd0;
         vwidth_ff    <= 4'd0;
         hsync_ff     <= 1'b0;
         vsync_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            sel_ff    <= sel_in;
            char_ff   <= char_in;
            row_ff    <= row_in;
            line_ff   <= line_in;
            hwidth_ff <= hwidth_in;
            vwidth_ff <= vwidth_in;
            hsync_ff  <= hsync_in;
            vsync_ff  <= vsync_in;
            if (wr_en) begin
               regs_ff[idx] <= wr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

[src/crtc_checker.sv]
// Port-level checker for the CRT timing controller and its bind statement.
// Depends on crtc_pkg and crt_timing_controller_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "crt_timing_controller_top_assert.svh"

module crtc_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire crtc_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire crtc_pkg::rsp_type rsp_data
);

   logic       req_fire;
   logic       rsp_held;
   logic       index_fire;
   logic       echo_ok;
   logic [7:0] last_byte_ff;

   assign req_fire   = req_valid && !req_stall;
   assign rsp_held   = rsp_valid && rsp_stall;
   assign index_fire = req_fire && (req_data.mode == crtc_pkg::MODE_WR_INDEX);
   assign echo_ok    = (rsp_data.read_byte == last_byte_ff) && !rsp_data.hsync_changed &&
                       !rsp_data.vsync_changed;

   always_ff @(posedge clock) begin
      last_byte_ff <= req_data.bus_byte;
   end

   `CRTC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_data))
   `CRTC_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_held)
   `CRTC_ASSERT_NEXT(a_result_follows, clock, reset, req_fire, rsp_valid)
   `CRTC_ASSERT_NEXT(a_index_echo, clock, reset, index_fire, echo_ok)

endmodule

bind crt_timing_controller_top crtc_checker u_crtc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
